[hdl/rari_pkg.sv]
// ----------------------------------------------------------------------------
// rari_pkg
// Shared types, constants and codes for the ray / rectangle intersect block.
// ----------------------------------------------------------------------------
package rari_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int T_EPSILON_DEF = 66;

	// numerator (corner - start) << F: 33 + F bits; QW is set to 34 bits
	localparam int QW = 34;

	typedef enum logic [2:0] {
		ST_PARALLEL = 3'd0,
		ST_BEHIND   = 3'd1,
		ST_BOUNDS   = 3'd2,
		ST_WINDOW   = 3'd3,
		ST_HIT      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_CORNER_X = 3'd0,
		REG_CORNER_Y = 3'd1,
		REG_CORNER_Z = 3'd2,
		REG_SIZE_X   = 3'd3,
		REG_SIZE_Y   = 3'd4,
		REG_SIZE_Z   = 3'd5,
		REG_FACING   = 3'd6
	} reg_idx_t;

	localparam logic [2:0] FACE_UP      = 3'd0;
	localparam logic [2:0] FACE_FORWARD = 3'd2;
	localparam logic [2:0] FACE_RIGHT   = 3'd4;

	localparam logic [1:0] AX_X = 2'd0;
	localparam logic [1:0] AX_Y = 2'd1;
	localparam logic [1:0] AX_Z = 2'd2;

	// per-ray side information carried along the divider
	typedef struct packed {
		logic               parallel;
		logic [1:0]         axis;
		logic               neg;
		logic               open_b;
		logic signed [31:0] s_a;
		logic signed [31:0] s_b;
		logic signed [31:0] d_a;
		logic signed [31:0] d_b;
		logic signed [32:0] lo_a;
		logic signed [32:0] hi_a;
		logic signed [32:0] lo_b;
		logic signed [32:0] hi_b;
		logic signed [31:0] limit;
	} side_t;

endpackage

[hdl/ray_axis_rectangle_intersect.sv]
// ----------------------------------------------------------------------------
// ray_axis_rectangle_intersect
// Ray against one axis-aligned rectangle held in configuration, Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Write the rectangle (corner, sizes, facing) through cfg_we / cfg_idx /
//   cfg_data while no ray is in flight. A ray is taken at a clock edge with
//   start high and busy low; busy is tied low, so one ray per cycle.
//   Each ray gives one result word, shown for one cycle with done high.
// Path from accept to done: the stage-1 register, the bit-per-stage divider,
//   then post stages A and B and the result register.
// Throughput: one ray per cycle.
// Reset clears all valid bits and loads the register reset values: corner
//   0, sizes 1.0, facing up. Results are not held: the receiver takes each
//   word in its done cycle and cannot stall the pipe.
// ----------------------------------------------------------------------------
module ray_axis_rectangle_intersect import rari_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int T_EPSILON = T_EPSILON_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [31:0] cfg_data,
	input  logic [31:0] start_x,
	input  logic [31:0] start_y,
	input  logic [31:0] start_z,
	input  logic [31:0] dir_x,
	input  logic [31:0] dir_y,
	input  logic [31:0] dir_z,
	input  logic [31:0] t_limit,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] t_value,
	output logic [1:0]  normal_axis,
	output logic        normal_negative
);

	localparam int NW = 33 + FRAC_BITS;

	logic signed [31:0] corner_q [3];
	logic [30:0]        size_q   [3];
	logic [2:0]         facing_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				corner_q[i] <= '0;
				size_q[i]   <= 31'(1) << FRAC_BITS;
			end
			facing_q <= FACE_UP;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_CORNER_X: corner_q[0] <= cfg_data;
				REG_CORNER_Y: corner_q[1] <= cfg_data;
				REG_CORNER_Z: corner_q[2] <= cfg_data;
				REG_SIZE_X:   size_q[0]   <= cfg_data[30:0];
				REG_SIZE_Y:   size_q[1]   <= cfg_data[30:0];
				REG_SIZE_Z:   size_q[2]   <= cfg_data[30:0];
				REG_FACING:   facing_q    <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// stage 1: axis pick, numerator, operand magnitudes
	logic signed [31:0] s [3];
	logic signed [31:0] d [3];
	assign s[0] = start_x; assign s[1] = start_y; assign s[2] = start_z;
	assign d[0] = dir_x;   assign d[1] = dir_y;   assign d[2] = dir_z;

	logic [1:0]         ax;
	logic               neg;
	logic [1:0]         ka, kb;
	logic signed [32:0] diff;
	logic signed [NW:0] num;
	logic signed [32:0] den;
	side_t              side;

	always_comb begin
		if (size_q[2] == '0) begin
			ax = AX_Z; neg = facing_q != FACE_UP;      ka = AX_X; kb = AX_Y;
		end else if (size_q[1] == '0) begin
			ax = AX_Y; neg = facing_q != FACE_FORWARD; ka = AX_X; kb = AX_Z;
		end else begin
			ax = AX_X; neg = facing_q != FACE_RIGHT;   ka = AX_Y; kb = AX_Z;
		end
		diff = 33'(corner_q[ax]) - 33'(s[ax]);
		num  = (NW+1)'(diff) <<< FRAC_BITS;
		den  = 33'(d[ax]);
		side.parallel = d[ax] == '0;
		side.axis     = ax;
		side.neg      = neg;
		side.open_b   = ax == AX_Z;
		side.s_a      = s[ka];
		side.s_b      = s[kb];
		side.d_a      = d[ka];
		side.d_b      = d[kb];
		side.lo_a     = 33'(corner_q[ka]);
		side.hi_a     = 33'(corner_q[ka]) + 33'({1'b0, size_q[ka]});
		side.lo_b     = 33'(corner_q[kb]);
		side.hi_b     = 33'(corner_q[kb]) + 33'({1'b0, size_q[kb]});
		side.limit    = t_limit;
	end

	logic          vld_s1;
	logic [NW-1:0] num_s1;
	logic [31:0]   den_s1;
	logic          neg_s1;
	side_t         side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start;
	end
	always_ff @(posedge clk) begin
		num_s1  <= num[NW] ? NW'(-num) : num[NW-1:0];
		// zero divisor only on parallel rays; result then ignored
		den_s1  <= side.parallel ? 32'd1 : (den[32] ? 32'(-den) : den[31:0]);
		neg_s1  <= (num[NW] ^ den[32]) && (num != '0);
		side_s1 <= side;
	end

	logic          vld_d;
	logic [NW-1:0] quo_d;
	logic          rnz_d, neg_d;
	side_t         side_d;

	rari_div #(.NW(NW), .DW(32)) u_div (
		.clk, .arst_n,
		.in_vld(vld_s1), .in_num(num_s1), .in_den(den_s1),
		.in_neg(neg_s1), .in_side(side_s1),
		.out_vld(vld_d), .out_quo(quo_d), .out_rem_nz(rnz_d),
		.out_neg(neg_d), .out_side(side_d)
	);

	rari_post #(.FRAC_BITS(FRAC_BITS), .T_EPSILON(T_EPSILON), .NW(NW)) u_post (
		.clk, .arst_n,
		.in_vld(vld_d), .in_quo(quo_d), .in_rem_nz(rnz_d), .in_neg(neg_d),
		.in_side(side_d),
		.done, .status, .t_value, .normal_axis, .normal_negative
	);

endmodule

[hdl/rari_div.sv]
// ----------------------------------------------------------------------------
// rari_div
// Pipelined restoring divider, one quotient bit per stage. Magnitudes are
// divided; sign and floor correction are applied downstream in rari_post. Side data
// travels with each word.
// ----------------------------------------------------------------------------
module rari_div import rari_pkg::*; #(
	parameter int NW = 64,   // numerator magnitude width
	parameter int DW = 32    // divisor magnitude width
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic          in_neg,    // quotient negative
	input  side_t         in_side,
	output logic          out_vld,
	output logic [NW-1:0] out_quo,
	output logic          out_rem_nz,
	output logic          out_neg,
	output side_t         out_side
);

	logic          vld_s [NW+1];
	logic [NW-1:0] q_s   [NW+1];
	logic [DW:0]   r_s   [NW+1];
	logic [DW-1:0] d_s   [NW+1];
	logic          n_s   [NW+1];
	side_t         sd_s  [NW+1];

	assign vld_s[0] = in_vld;
	assign q_s[0]   = in_num;
	assign r_s[0]   = '0;
	assign d_s[0]   = in_den;
	assign n_s[0]   = in_neg;
	assign sd_s[0]  = in_side;

	for (genvar i = 0; i < NW; i++) begin : g_stage
		logic [DW:0]   trial;
		logic [DW+1:0] diff;
		assign trial = {r_s[i][DW-1:0], q_s[i][NW-1]};
		assign diff  = {1'b0, trial} - {2'b00, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else         vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			if (diff[DW+1]) begin
				r_s[i+1] <= trial;
				q_s[i+1] <= {q_s[i][NW-2:0], 1'b0};
			end else begin
				r_s[i+1] <= diff[DW:0];
				q_s[i+1] <= {q_s[i][NW-2:0], 1'b1};
			end
			d_s[i+1]  <= d_s[i];
			n_s[i+1]  <= n_s[i];
			sd_s[i+1] <= sd_s[i];
		end
	end

	assign out_vld    = vld_s[NW];
	assign out_quo    = q_s[NW];
	assign out_rem_nz = |r_s[NW];
	assign out_neg    = n_s[NW];
	assign out_side   = sd_s[NW];

endmodule

[hdl/rari_post.sv]
// ----------------------------------------------------------------------------
// rari_post
// Back end: signed floor quotient and saturation, off-axis point products,
// bounds and window checks, result register.
// ----------------------------------------------------------------------------
module rari_post import rari_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int T_EPSILON = T_EPSILON_DEF,
	parameter int NW        = 32 + FRAC_BITS + 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [NW-1:0] in_quo,
	input  logic          in_rem_nz,
	input  logic          in_neg,
	input  side_t         in_side,
	output logic          done,
	output logic [2:0]    status,
	output logic [31:0]   t_value,
	output logic [1:0]    normal_axis,
	output logic          normal_negative
);

	localparam logic signed [31:0] EPS = 32'(T_EPSILON);
	localparam logic signed [31:0] MINUS_ONE = -(32'sd1 <<< FRAC_BITS);

	// stage A: signed floor quotient, saturate
	logic signed [NW:0] qs;
	logic signed [31:0] tq;
	always_comb begin
		qs = in_neg ? -$signed({1'b0, in_quo}) - (in_rem_nz ? 1 : 0)
		            : $signed({1'b0, in_quo});
		if (qs > $signed((NW+1)'(32'h7fffffff)))   tq = 32'sh7fffffff;
		else if (qs < -$signed((NW+1)'(33'h80000000))) tq = 32'sh80000000;
		else tq = qs[31:0];
	end

	logic               vld_a;
	logic signed [31:0] t_a;
	side_t              sd_a;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_a <= 1'b0;
		else         vld_a <= in_vld;
	end
	always_ff @(posedge clk) begin
		t_a  <= tq;
		sd_a <= in_side;
	end

	// stage B: products t * d, one 32x32 each
	logic               vld_b;
	logic signed [31:0] t_b;
	logic signed [63:0] pa_b, pb_b;
	side_t              sd_b;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_b <= 1'b0;
		else         vld_b <= vld_a;
	end
	always_ff @(posedge clk) begin
		t_b  <= t_a;
		pa_b <= t_a * sd_a.d_a;
		pb_b <= t_a * sd_a.d_b;
		sd_b <= sd_a;
	end

	// stage C: points and checks
	logic signed [64:0] pt_a, pt_b;
	logic               in_a, in_b;
	status_t            st;
	always_comb begin
		// arithmetic shift is the floor division
		pt_a = 65'(sd_b.s_a) + 65'(pa_b >>> FRAC_BITS);
		pt_b = 65'(sd_b.s_b) + 65'(pb_b >>> FRAC_BITS);
		if (sd_b.open_b) begin
			in_a = pt_a > 65'(sd_b.lo_a) && pt_a < 65'(sd_b.hi_a);
			in_b = pt_b > 65'(sd_b.lo_b) && pt_b < 65'(sd_b.hi_b);
		end else begin
			in_a = pt_a >= 65'(sd_b.lo_a) && pt_a <= 65'(sd_b.hi_a);
			in_b = pt_b >= 65'(sd_b.lo_b) && pt_b <= 65'(sd_b.hi_b);
		end
		priority if (sd_b.parallel)            st = ST_PARALLEL;
		else if (t_b < 0)                       st = ST_BEHIND;
		else if (!(in_a && in_b))               st = ST_BOUNDS;
		else if (t_b > sd_b.limit || t_b <= EPS) st = ST_WINDOW;
		else                                    st = ST_HIT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= vld_b;
	end
	always_ff @(posedge clk) begin
		status          <= st;
		t_value         <= (st == ST_HIT) ? t_b : MINUS_ONE;
		normal_axis     <= sd_b.axis;
		normal_negative <= sd_b.neg;
	end

endmodule

[hdl/rari_chk.sv]
// ----------------------------------------------------------------------------
// rari_chk
// Port-level checks on busy and the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module rari_chk import rari_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [31:0] t_value,
	input logic [1:0]  normal_axis
);

	a_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_PARALLEL || status == ST_BEHIND ||
		          status == ST_BOUNDS || status == ST_WINDOW || status == ST_HIT))
		else $error("bad status");
	a_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != ST_HIT) |-> t_value[31])
		else $error("miss without negative t");
	a_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_HIT) |-> !t_value[31])
		else $error("hit with negative t");
	a_axis: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (normal_axis == AX_X || normal_axis == AX_Y || normal_axis == AX_Z))
		else $error("bad axis");

endmodule

bind ray_axis_rectangle_intersect rari_chk u_chk (
	.clk, .arst_n, .busy, .done, .status, .t_value, .normal_axis
);
